/* sv/eic_pkg.sv */
// shared types and codes of the external interrupt controller
package eic_pkg;

    localparam int ExtLines = 3;
    localparam int PcGroups = 4;
    localparam int SenseBits = 2;

    localparam logic [1:0] ModeRead = 2'd0;
    localparam logic [1:0] ModeWrite = 2'd1;
    localparam logic [1:0] ModePins = 2'd2;
    localparam logic [1:0] ModeAck = 2'd3;

    localparam logic [2:0] RegSense = 3'd0;
    localparam logic [2:0] RegExtMask = 3'd1;
    localparam logic [2:0] RegExtFlags = 3'd2;
    localparam logic [2:0] RegPcControl = 3'd3;
    localparam logic [2:0] RegPcFlags = 3'd4;

    localparam logic [1:0] SenseLow = 2'd0;
    localparam logic [1:0] SenseAny = 2'd1;
    localparam logic [1:0] SenseFall = 2'd2;
    localparam logic [1:0] SenseRise = 2'd3;

    typedef struct packed {
        logic [1:0]          mode;
        logic [2:0]          reg_index;
        logic [7:0]          write_value;
        logic [ExtLines-1:0] ext_pins;
        logic [PcGroups-1:0] pc_pins;
        logic [ExtLines-1:0] ack_ext;
        logic [PcGroups-1:0] ack_pc;
    } in_item_t;

    typedef struct packed {
        logic [7:0]          read_data;
        logic [ExtLines-1:0] ext_irq;
        logic [PcGroups-1:0] pc_irq;
    } out_item_t;

endpackage

/* sv/eic_if.sv */
// valid/ready channel interfaces for requests and results
interface eic_in_if;
    logic               valid;
    logic               ready;
    eic_pkg::in_item_t  data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface eic_out_if;
    logic               valid;
    logic               ready;
    eic_pkg::out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* sv/external_interrupt_controller.sv */
// external and pin-change interrupt controller top level
//
//  channel   dir   payload                                         per transfer
//  in_ch     in    mode, reg_index, write_value, pins, acks        one request
//  out_ch    out   read_data, ext_irq, pc_irq                      one result
//
// each request is applied to the registers in the cycle it is taken and its
// result appears in the output register on the next cycle
// one request per cycle while no result is stalled; the result is held in the single result register
// reset clears all registers but the result data; last external pin sample resets to all ones
// in_ch.ready drops only while a result is held and out_ch.ready is low
module external_interrupt_controller (
    input  logic      clk,
    input  logic      rst_n,
    eic_in_if.sink    in_ch,
    eic_out_if.source out_ch
);

    logic [7:0]                    sense_reg, sense_next;
    logic [7:0]                    ext_mask_reg, ext_mask_next;
    logic [eic_pkg::ExtLines-1:0]  ext_flags_reg, ext_flags_next;
    logic [7:0]                    pc_control_reg, pc_control_next;
    logic [eic_pkg::PcGroups-1:0]  pc_flags_reg, pc_flags_next;
    logic [eic_pkg::ExtLines-1:0]  last_ext_reg, last_ext_next;
    logic [eic_pkg::PcGroups-1:0]  last_pc_reg, last_pc_next;
    logic                          out_valid_reg;
    eic_pkg::out_item_t            out_data_reg, out_data_next;
    logic                          accept;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;
    assign out_ch.valid = out_valid_reg;
    assign out_ch.data = out_data_reg;

    always_comb
    begin
        logic [eic_pkg::ExtLines-1:0] clr;
        logic [eic_pkg::ExtLines-1:0] chg;
        logic [1:0]                   code;
        logic [7:0]                   rd;

        sense_next = sense_reg;
        ext_mask_next = ext_mask_reg;
        ext_flags_next = ext_flags_reg;
        pc_control_next = pc_control_reg;
        pc_flags_next = pc_flags_reg;
        last_ext_next = last_ext_reg;
        last_pc_next = last_pc_reg;
        clr = in_ch.data.write_value[eic_pkg::ExtLines-1:0];
        chg = in_ch.data.ext_pins ^ last_ext_reg;
        code = '0;
        rd = 8'd0;

        case (in_ch.data.mode)
            eic_pkg::ModeRead:
            begin
                case (in_ch.data.reg_index)
                    eic_pkg::RegSense:     rd = sense_reg;
                    eic_pkg::RegExtMask:   rd = ext_mask_reg;
                    eic_pkg::RegExtFlags:  rd = 8'(ext_flags_reg);
                    eic_pkg::RegPcControl: rd = pc_control_reg;
                    eic_pkg::RegPcFlags:   rd = 8'(pc_flags_reg);
                    default:               rd = 8'd0;
                endcase
            end
            eic_pkg::ModeWrite:
            begin
                case (in_ch.data.reg_index)
                    eic_pkg::RegSense:
                    begin
                        sense_next = in_ch.data.write_value;
                        for (int i = 0; i < eic_pkg::ExtLines; i++)
                        begin
                            code = in_ch.data.write_value[i*eic_pkg::SenseBits +: 2];
                            if (ext_mask_reg[i] && code == eic_pkg::SenseLow)
                            begin
                                ext_flags_next[i] = !last_ext_reg[i];
                            end
                        end
                    end
                    eic_pkg::RegExtMask:
                    begin
                        ext_mask_next = in_ch.data.write_value;
                    end
                    eic_pkg::RegExtFlags:
                    begin
                        if (|(ext_flags_reg & clr))
                        begin
                            for (int i = 0; i < eic_pkg::ExtLines; i++)
                            begin
                                code = sense_reg[i*eic_pkg::SenseBits +: 2];
                                if (clr[i])
                                begin
                                    ext_flags_next[i] = code == eic_pkg::SenseLow
                                        && !last_ext_reg[i] && ext_mask_reg[i];
                                end
                            end
                        end
                    end
                    eic_pkg::RegPcControl:
                    begin
                        pc_control_next = in_ch.data.write_value;
                    end
                    eic_pkg::RegPcFlags:
                    begin
                        pc_flags_next = pc_flags_reg
                            & ~in_ch.data.write_value[eic_pkg::PcGroups-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
            eic_pkg::ModePins:
            begin
                for (int i = 0; i < eic_pkg::ExtLines; i++)
                begin
                    code = sense_reg[i*eic_pkg::SenseBits +: 2];
                    if (ext_mask_reg[i])
                    begin
                        case (code)
                            eic_pkg::SenseLow:
                                ext_flags_next[i] = !in_ch.data.ext_pins[i];
                            eic_pkg::SenseAny:
                                ext_flags_next[i] = ext_flags_reg[i] | chg[i];
                            eic_pkg::SenseFall:
                                ext_flags_next[i] = ext_flags_reg[i]
                                    | (chg[i] & !in_ch.data.ext_pins[i]);
                            default:
                                ext_flags_next[i] = ext_flags_reg[i]
                                    | (chg[i] & in_ch.data.ext_pins[i]);
                        endcase
                    end
                end
                pc_flags_next = pc_flags_reg | ((in_ch.data.pc_pins ^ last_pc_reg)
                    & pc_control_reg[eic_pkg::PcGroups-1:0]);
                last_ext_next = in_ch.data.ext_pins;
                last_pc_next = in_ch.data.pc_pins;
            end
            default:
            begin
                ext_flags_next = ext_flags_reg & ~in_ch.data.ack_ext;
                pc_flags_next = pc_flags_reg & ~in_ch.data.ack_pc;
            end
        endcase

        out_data_next.read_data = rd;
        out_data_next.ext_irq = ext_mask_next[eic_pkg::ExtLines-1:0] & ext_flags_next;
        out_data_next.pc_irq = pc_control_next[eic_pkg::PcGroups-1:0] & pc_flags_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sense_reg <= '0;
            ext_mask_reg <= '0;
            ext_flags_reg <= '0;
            pc_control_reg <= '0;
            pc_flags_reg <= '0;
            last_ext_reg <= '1;
            last_pc_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sense_reg <= sense_next;
                ext_mask_reg <= ext_mask_next;
                ext_flags_reg <= ext_flags_next;
                pc_control_reg <= pc_control_next;
                pc_flags_reg <= pc_flags_next;
                last_ext_reg <= last_ext_next;
                last_pc_reg <= last_pc_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

endmodule

/* sv/eic_checker.sv */
// port-level checks of the external interrupt controller, with its bind
module eic_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input eic_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input eic_pkg::out_item_t out_data
);

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // every request gives a result on the next cycle
    a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> out_valid)
        else $error("no result after request transfer");

    // only reads return data
    a_read_only: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && in_data.mode != eic_pkg::ModeRead |=> out_data.read_data == 8'd0)
        else $error("nonzero read data on a non-read request");

    // request side stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("request side stalled without cause");

endmodule

bind external_interrupt_controller eic_checker u_eic_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_data   (in_ch.data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);

/* verif/tb_external_interrupt_controller.sv */
// testbench of the external and pin-change interrupt controller: directed and random requests
`timescale 1ns / 1ps

module tb_external_interrupt_controller;

    localparam int StallLimit = 2000;
    localparam int HoldCycles = 80;
    localparam int PhaseItems = 250;

    class irq_scoreboard;
        logic [7:0]                   sense_ctl;
        logic [7:0]                   ext_mask;
        logic [eic_pkg::ExtLines-1:0] ext_flags;
        logic [7:0]                   pc_ctl;
        logic [eic_pkg::PcGroups-1:0] pc_flags;
        logic [eic_pkg::ExtLines-1:0] last_ext;
        logic [eic_pkg::PcGroups-1:0] last_pc;
        eic_pkg::out_item_t           expected_q[$];
        int                           errors;

        function new();
            sense_ctl = '0;
            ext_mask = '0;
            ext_flags = '0;
            pc_ctl = '0;
            pc_flags = '0;
            last_ext = '1;
            last_pc = '0;
            errors = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // apply one accepted request and queue the result it should give
        function void note(eic_pkg::in_item_t it);
            eic_pkg::out_item_t           res;
            logic [eic_pkg::ExtLines-1:0] clr;
            logic [eic_pkg::ExtLines-1:0] chg;
            logic [1:0]                   code;
            logic                         hit;
            res = '0;
            case (it.mode)
                eic_pkg::ModeRead:
                begin
                    case (it.reg_index)
                        eic_pkg::RegSense: res.read_data = sense_ctl;
                        eic_pkg::RegExtMask: res.read_data = ext_mask;
                        eic_pkg::RegExtFlags: res.read_data = 8'(ext_flags);
                        eic_pkg::RegPcControl: res.read_data = pc_ctl;
                        eic_pkg::RegPcFlags: res.read_data = 8'(pc_flags);
                        default: res.read_data = '0;
                    endcase
                end
                eic_pkg::ModeWrite:
                begin
                    case (it.reg_index)
                        eic_pkg::RegSense:
                        begin
                            sense_ctl = it.write_value;
                            for (int i = 0; i < eic_pkg::ExtLines; i++)
                            begin
                                code = sense_ctl[eic_pkg::SenseBits*i +: eic_pkg::SenseBits];
                                if (ext_mask[i] && code == eic_pkg::SenseLow)
                                    ext_flags[i] = ~last_ext[i];
                            end
                        end
                        eic_pkg::RegExtMask: ext_mask = it.write_value;
                        eic_pkg::RegExtFlags:
                        begin
                            clr = it.write_value[eic_pkg::ExtLines-1:0];
                            if ((ext_flags & clr) != '0)
                            begin
                                ext_flags = ext_flags & ~clr;
                                // level lines with the pin still low fire again
                                for (int i = 0; i < eic_pkg::ExtLines; i++)
                                begin
                                    code = sense_ctl[eic_pkg::SenseBits*i +: eic_pkg::SenseBits];
                                    if (clr[i] && ext_mask[i] && !last_ext[i] &&
                                        code == eic_pkg::SenseLow)
                                        ext_flags[i] = 1'b1;
                                end
                            end
                        end
                        eic_pkg::RegPcControl: pc_ctl = it.write_value;
                        eic_pkg::RegPcFlags:
                            pc_flags = pc_flags & ~it.write_value[eic_pkg::PcGroups-1:0];
                        default: ;
                    endcase
                end
                eic_pkg::ModePins:
                begin
                    chg = it.ext_pins ^ last_ext;
                    for (int i = 0; i < eic_pkg::ExtLines; i++)
                    begin
                        if (ext_mask[i])
                        begin
                            code = sense_ctl[eic_pkg::SenseBits*i +: eic_pkg::SenseBits];
                            case (code)
                                eic_pkg::SenseLow: hit = !it.ext_pins[i];
                                eic_pkg::SenseAny: hit = chg[i];
                                eic_pkg::SenseFall: hit = chg[i] && !it.ext_pins[i];
                                default: hit = chg[i] && it.ext_pins[i];
                            endcase
                            if (code == eic_pkg::SenseLow)
                                ext_flags[i] = hit;
                            else if (hit)
                                ext_flags[i] = 1'b1;
                        end
                    end
                    pc_flags = pc_flags
                        | ((it.pc_pins ^ last_pc) & pc_ctl[eic_pkg::PcGroups-1:0]);
                    last_ext = it.ext_pins;
                    last_pc = it.pc_pins;
                end
                default:
                begin
                    ext_flags = ext_flags & ~it.ack_ext;
                    pc_flags = pc_flags & ~it.ack_pc;
                end
            endcase
            res.ext_irq = ext_mask[eic_pkg::ExtLines-1:0] & ext_flags;
            res.pc_irq = pc_ctl[eic_pkg::PcGroups-1:0] & pc_flags;
            expected_q.push_back(res);
        endfunction

        function void check(eic_pkg::out_item_t got);
            eic_pkg::out_item_t exp_res;
            if (expected_q.size() == 0)
            begin
                $error("unexpected result transfer: read_data %0h ext_irq %0h pc_irq %0h",
                       got.read_data, got.ext_irq, got.pc_irq);
                errors++;
                return;
            end
            exp_res = expected_q.pop_front();
            if (got.read_data !== exp_res.read_data)
            begin
                $error("read_data: expected %0h, actual %0h", exp_res.read_data, got.read_data);
                errors++;
            end
            if (got.ext_irq !== exp_res.ext_irq)
            begin
                $error("ext_irq: expected %0h, actual %0h", exp_res.ext_irq, got.ext_irq);
                errors++;
            end
            if (got.pc_irq !== exp_res.pc_irq)
            begin
                $error("pc_irq: expected %0h, actual %0h", exp_res.pc_irq, got.pc_irq);
                errors++;
            end
        endfunction
    endclass

    logic          clk;
    logic          rst_n;
    eic_in_if      in_ch ();
    eic_out_if     out_ch ();
    irq_scoreboard sb;
    int            tx_idle_pct;
    int            rx_idle_pct;
    logic          hold_toggle;
    int            quiet_cycles;

    external_interrupt_controller u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #5 clk = ~clk;

    function automatic eic_pkg::in_item_t make_item(logic [1:0] mode, logic [2:0] idx,
                                                    logic [7:0] wv,
                                                    logic [2:0] ep, logic [3:0] pp,
                                                    logic [2:0] ae, logic [3:0] ap);
        eic_pkg::in_item_t it;
        it.mode = mode;
        it.reg_index = idx;
        it.write_value = wv;
        it.ext_pins = ep;
        it.pc_pins = pp;
        it.ack_ext = ae;
        it.ack_pc = ap;
        return it;
    endfunction

    function automatic eic_pkg::in_item_t random_item();
        eic_pkg::in_item_t it;
        int                pick;
        it = eic_pkg::in_item_t'($bits(eic_pkg::in_item_t)'($urandom));
        pick = $urandom_range(99);
        if (pick < 20)
            it.mode = eic_pkg::ModeRead;
        else if (pick < 45)
            it.mode = eic_pkg::ModeWrite;
        else if (pick < 85)
            it.mode = eic_pkg::ModePins;
        else
            it.mode = eic_pkg::ModeAck;
        if ($urandom_range(99) < 85)
            it.reg_index = 3'($urandom_range(4));
        else
            it.reg_index = 3'($urandom_range(7, 5));
        // keep most lines enabled so flags actually get set
        if (it.mode == eic_pkg::ModeWrite && $urandom_range(99) < 70)
        begin
            if (it.reg_index == eic_pkg::RegExtMask)
                it.write_value[eic_pkg::ExtLines-1:0] = '1;
            else if (it.reg_index == eic_pkg::RegPcControl)
                it.write_value[eic_pkg::PcGroups-1:0] = '1;
        end
        return it;
    endfunction

    task automatic send_item(input eic_pkg::in_item_t it);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        sb.note(it);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_item(random_item());
            if (n == count / 2)
                wait_drained();
        end
    endtask

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int   stall_left;
        logic seen;
        out_ch.ready = 1'b0;
        stall_left = 0;
        seen = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_ch.valid && out_ch.ready)
                sb.check(out_ch.data);
            if (hold_toggle != seen)
            begin
                seen = hold_toggle;
                stall_left = HoldCycles;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end
            else
            begin
                out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= StallLimit)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        hold_toggle = 1'b0;
        tx_idle_pct = 7;
        rx_idle_pct = 82;
        sb = new();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        send_item(make_item(eic_pkg::ModeRead, eic_pkg::RegSense,
                            8'h00, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeRead, 3'd7, 8'hff, 3'h7, 4'hf, 3'h7, 4'hf));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegExtMask,
                            8'hff, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegPcControl,
                            8'hff, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegSense,
                            8'h00, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModePins, eic_pkg::RegSense,
                            8'h00, 3'h0, 4'hf, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegExtFlags,
                            8'hff, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegPcFlags,
                            8'hff, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModePins, eic_pkg::RegSense,
                            8'h00, 3'h7, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegExtFlags,
                            8'h07, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegSense,
                            8'he4, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModePins, eic_pkg::RegSense,
                            8'h00, 3'h0, 4'h5, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeAck, eic_pkg::RegSense,
                            8'h00, 3'h0, 4'h0, 3'h7, 4'hf));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegSense,
                            8'hff, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModePins, eic_pkg::RegSense,
                            8'h00, 3'h7, 4'ha, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModePins, eic_pkg::RegSense,
                            8'h00, 3'h7, 4'ha, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeAck, eic_pkg::RegSense,
                            8'h00, 3'h0, 4'h0, 3'h5, 4'h0));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegExtMask,
                            8'h00, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeRead, eic_pkg::RegExtFlags,
                            8'h00, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeWrite, 3'd5, 8'haa, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeRead, 3'd6, 8'h00, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeWrite, eic_pkg::RegPcControl,
                            8'ha5, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeRead, eic_pkg::RegPcControl,
                            8'h00, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeRead, eic_pkg::RegExtMask,
                            8'h00, 3'h0, 4'h0, 3'h0, 4'h0));
        send_item(make_item(eic_pkg::ModeRead, eic_pkg::RegPcFlags,
                            8'h00, 3'h0, 4'h0, 3'h0, 4'h0));

        run_random(PhaseItems);

        tx_idle_pct = 82;
        rx_idle_pct = 7;
        run_random(PhaseItems);

        // no idling: long result stall while requests keep coming
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        wait_drained();
        hold_toggle <= ~hold_toggle;
        run_random(PhaseItems);

        wait_drained();
        repeat (3) @(posedge clk);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
